>>> design/longest_ones_window_with_flips_defines.svh
// Assertion macros for the longest-ones window block.
// Included by the FIFO and top-level modules; needs clk and rst in scope.
`ifndef LONGEST_ONES_WINDOW_WITH_FLIPS_DEFINES_SVH
`define LONGEST_ONES_WINDOW_WITH_FLIPS_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define LOWF_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define LOWF_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LOWF_CHECK(lbl, ante, cons, msg)
`define LOWF_CHECK_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/lowf_pkg.sv
// Shared types for the longest-ones window block.
// No dependencies.
package lowf_pkg;

  // request from the front stage to the zero FIFO
  typedef struct packed {
    logic step;   // a transaction is accepted this cycle
    logic push;   // item is a zero inside the counted range
    logic clear;  // end of stream: drop all entries
  } fifo_ctl_t;

  // FIFO answer for the current transaction
  typedef struct packed {
    logic pop;    // budget exceeded, oldest zero leaves the window
    logic fwd;    // popped zero is the one pushed now (FIFO was empty)
  } fifo_stat_t;

endpackage

>>> design/lowf_ifs.sv
// Valid/ready channel interfaces for the longest-ones window block.
// No dependencies.
interface lowf_bit_if;
  logic valid;
  logic ready;
  logic in_bit;
  logic in_last;

  modport source (output valid, output in_bit, output in_last, input ready);
  modport sink   (input valid, input in_bit, input in_last, output ready);
endinterface

interface lowf_result_if #(
  parameter int PosW = 17,
  parameter int IdxW = 16
);
  logic            valid;
  logic            ready;
  logic [PosW-1:0] best_start;
  logic [IdxW-1:0] best_end;
  logic [PosW-1:0] best_length;
  logic            overflow;

  modport source (output valid, output best_start, output best_end, output best_length,
                  output overflow, input ready);
  modport sink   (input valid, input best_start, input best_end, input best_length,
                  input overflow, output ready);
endinterface

>>> design/lowf_zero_fifo.sv
// Zero-position FIFO: synchronous memory, pointers, occupancy and pop decision.
// Depends on lowf_pkg and longest_ones_window_with_flips_defines.svh.
`include "longest_ones_window_with_flips_defines.svh"

module lowf_zero_fifo import lowf_pkg::*; #(
  parameter int MAX_FLIPS = 255,
  parameter int IdxW      = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      budget,
  input  fifo_ctl_t       ctl,
  input  logic [IdxW-1:0] wdata,
  output fifo_stat_t      stat,
  output logic [IdxW-1:0] rd_data
);

  localparam int Depth = MAX_FLIPS + 1;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int CmpW  = (CntW > 8) ? CntW : 8;

  logic [IdxW-1:0] mem [Depth];
  logic [PtrW-1:0] head;
  logic [PtrW-1:0] tail;
  logic [CntW-1:0] cnt;

  logic [PtrW-1:0] head_next;
  logic [PtrW-1:0] tail_next;
  logic [CmpW-1:0] eff_budget;
  logic [CmpW-1:0] cnt_inc;

  assign head_next = (head == PtrW'(Depth - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == PtrW'(Depth - 1)) ? '0 : tail + 1'b1;

  // budget saturates at MAX_FLIPS, one below the FIFO memory depth
  assign eff_budget = (CmpW'(budget) > CmpW'(MAX_FLIPS)) ? CmpW'(MAX_FLIPS) : CmpW'(budget);
  assign cnt_inc    = CmpW'(cnt) + CmpW'(1);

  assign stat.pop = ctl.push && (cnt_inc > eff_budget);
  assign stat.fwd = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else if (ctl.step) begin
      if (ctl.clear) begin
        head <= '0;
        tail <= '0;
        cnt  <= '0;
      end else if (ctl.push) begin
        tail <= tail_next;
        if (stat.pop) begin
          head <= head_next;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // write at tail, read at head; same entry only when empty, covered by fwd
  always_ff @(posedge clk) begin
    if (ctl.step && ctl.push) begin
      mem[tail] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      rd_data <= mem[head];
    end
  end

  `LOWF_CHECK(a_cnt_bound, 1'b1, cnt <= CntW'(MAX_FLIPS), "zero count above capacity")
  `LOWF_CHECK(a_fwd_pop, ctl.step && stat.fwd && stat.pop, ctl.push, "forward without push")
  `LOWF_CHECK(a_pop_push, stat.pop, ctl.push, "pop without push")
  `LOWF_CHECK_NEXT(a_clear, ctl.step && ctl.clear, (cnt == '0) && (head == tail),
                   "FIFO not empty after end of stream")

endmodule

>>> design/longest_ones_window_with_flips.sv
// Top level: longest run of ones with up to flip_budget zeros flipped.
// Depends on lowf_pkg, lowf_ifs, lowf_zero_fifo and the defines header.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------
//  bits     | in  | valid/ready    | in_bit, in_last
//  result   | out | valid/ready    | best_start, best_end, best_length, overflow
//  cfg      | in  | cfg_wen        | cfg_wdata -> flip_budget
//
// One transaction per cycle, back to back, unless stalled. A result is registered
// once the transaction that carries in_last passes FIFO read, then window update.
// The only stall: a second end-of-stream item reaches the update stage while
// the previous result is still unaccepted; bits.ready drops until it is taken.
// Reset is synchronous; the FIFO memory is not cleared (entries read only
// after being written). flip_budget resets to 0.
`include "longest_ones_window_with_flips_defines.svh"

module longest_ones_window_with_flips import lowf_pkg::*; #(
  parameter int MAX_FLIPS = 255,
  parameter int MAX_LEN   = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [7:0]           cfg_wdata,
  lowf_bit_if.sink             bits,
  lowf_result_if.source        result
);

  localparam int PosW = $clog2(MAX_LEN + 1);   // position counter, saturates at MAX_LEN
  localparam int IdxW = $clog2(MAX_LEN);       // index of an item in range

  // ---------------- configuration ----------------
  logic [7:0] flip_budget;

  always_ff @(posedge clk) begin
    if (rst) begin
      flip_budget <= '0;
    end else if (cfg_wen) begin
      flip_budget <= cfg_wdata;
    end
  end

  // ---------------- stage 1: position and FIFO push/pop ----------------
  logic            accept;
  logic            stall;
  logic            active;
  logic [PosW-1:0] position;
  logic            overflowed;

  fifo_ctl_t       fctl;
  fifo_stat_t      fstat;
  logic [IdxW-1:0] rd_data;

  assign accept = bits.valid && bits.ready;
  assign active = position < PosW'(MAX_LEN);   // items past MAX_LEN only flag overflow

  assign fctl.step  = accept;
  assign fctl.push  = active && !bits.in_bit;
  assign fctl.clear = bits.in_last;

  lowf_zero_fifo #(
    .MAX_FLIPS (MAX_FLIPS),
    .IdxW      (IdxW)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .budget  (flip_budget),
    .ctl     (fctl),
    .wdata   (position[IdxW-1:0]),
    .stat    (fstat),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      overflowed <= 1'b0;
    end else if (accept) begin
      if (bits.in_last) begin
        position   <= '0;
        overflowed <= 1'b0;
      end else if (active) begin
        position <= position + 1'b1;
      end else begin
        overflowed <= 1'b1;
      end
    end
  end

  // stage 1 -> stage 2 register; rd_data arrives alongside
  logic            s2_valid;
  logic [PosW-1:0] s2_pos;
  logic            s2_active;
  logic            s2_pop;
  logic            s2_fwd;
  logic            s2_last;
  logic            s2_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept) begin
      s2_valid <= 1'b1;
    end else if (!stall) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_pos    <= position;
      s2_active <= active;
      s2_pop    <= fstat.pop;
      s2_fwd    <= fstat.fwd;
      s2_last   <= bits.in_last;
      s2_ovf    <= overflowed || !active;
    end
  end

  // ---------------- stage 2: window start and best tracking ----------------
  logic            adv;
  logic [PosW-1:0] window_start;
  logic [PosW-1:0] longest;
  logic [PosW-1:0] longest_start;
  logic [IdxW-1:0] longest_end;
  logic            have_any;

  logic [PosW-1:0] oldest;
  logic [PosW-1:0] ws;
  logic [PosW-1:0] len;
  logic            better;

  // oldest zero: the just-pushed one when the FIFO was empty, else memory
  assign oldest = s2_fwd ? s2_pos : PosW'(rd_data);
  assign ws     = s2_pop ? oldest + 1'b1 : window_start;
  assign len    = s2_pos + 1'b1 - ws;
  // strict compare keeps the earliest window on ties; first item always taken
  assign better = s2_active && (!have_any || (len > longest));

  assign stall      = s2_valid && s2_last && result.valid && !result.ready;
  assign adv        = s2_valid && !stall;
  assign bits.ready = !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start  <= '0;
      longest       <= '0;
      longest_start <= '0;
      longest_end   <= '0;
      have_any      <= 1'b0;
    end else if (adv) begin
      if (s2_last) begin
        window_start  <= '0;
        longest       <= '0;
        longest_start <= '0;
        longest_end   <= '0;
        have_any      <= 1'b0;
      end else if (s2_active) begin
        window_start <= ws;
        if (better) begin
          have_any      <= 1'b1;
          longest       <= len;
          longest_start <= ws;
          longest_end   <= s2_pos[IdxW-1:0];
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic            res_valid;
  logic [PosW-1:0] res_start;
  logic [IdxW-1:0] res_end;
  logic [PosW-1:0] res_len;
  logic            res_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && s2_last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_last) begin
      res_start <= better ? ws : longest_start;
      res_end   <= better ? s2_pos[IdxW-1:0] : longest_end;
      res_len   <= better ? len : longest;
      res_ovf   <= s2_ovf;
    end
  end

  assign result.valid       = res_valid;
  assign result.best_start  = res_start;
  assign result.best_end    = res_end;
  assign result.best_length = res_len;
  assign result.overflow    = res_ovf;

  `LOWF_CHECK_NEXT(a_result_load, adv && s2_last, result.valid,
                   "end of stream did not produce a result")
  `LOWF_CHECK(a_empty_best, !have_any, longest == '0, "best length set without a window")
  `LOWF_CHECK(a_start_bound, 1'b1, window_start <= PosW'(MAX_LEN),
              "window start past stream limit")

endmodule

>>> tb/tb_longest_ones_window_with_flips.sv
`timescale 1ns / 100ps
// Self-checking bench for longest_ones_window_with_flips: bit stream in, best window out.
// Depends on lowf_ifs and the block itself; a scoreboard class predicts each stream result.

module tb_longest_ones_window_with_flips;
  localparam int MAX_FLIPS = 255;
  localparam int MAX_LEN   = 65536;

  typedef struct packed {
    logic [16:0] start_idx;
    logic [15:0] end_idx;
    logic [16:0] run_len;
    logic        ovf;
  } window_result_t;

  class window_scoreboard;
    int unsigned    budget;
    int unsigned    pos;
    int unsigned    win_start;
    int unsigned    zero_idx[$];
    int unsigned    best_len;
    int unsigned    best_start;
    int unsigned    best_end;
    bit             seen_any;
    bit             went_long;
    window_result_t expected_windows[$];
    int unsigned    errors;

    function new();
      budget = 0;
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      pos = 0;
      win_start = 0;
      zero_idx.delete();
      best_len = 0;
      best_start = 0;
      best_end = 0;
      seen_any = 0;
      went_long = 0;
    endfunction

    function void set_budget(logic [7:0] value);
      budget = value;
    endfunction

    function int pending();
      return expected_windows.size();
    endfunction

    // One accepted bit transaction; queues a window on the end mark.
    function void note_bit(bit b, bit is_last);
      int unsigned cap;
      int unsigned len;
      window_result_t w;
      cap = (budget > MAX_FLIPS) ? MAX_FLIPS : budget;
      if (pos >= MAX_LEN) begin
        went_long = 1;
      end else begin
        if (!b) begin
          zero_idx = {zero_idx, pos};
          if (zero_idx.size() > cap) win_start = zero_idx.pop_front() + 1;
        end
        len = pos + 1 - win_start;
        // strictly longer only: earliest window wins ties
        if (!seen_any || len > best_len) begin
          seen_any = 1;
          best_len = len;
          best_start = win_start;
          best_end = pos;
        end
        pos++;
      end
      if (is_last) begin
        w.start_idx = best_start[16:0];
        w.end_idx = best_end[15:0];
        w.run_len = best_len[16:0];
        w.ovf = went_long;
        expected_windows = {expected_windows, w};
        clear_stream();
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_window(window_result_t got);
      window_result_t exp_w;
      if (expected_windows.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual start %0d end %0d len %0d ovf %0d",
                 $time, got.start_idx, got.end_idx, got.run_len, got.ovf);
        errors++;
        return;
      end
      exp_w = expected_windows.pop_front();
      compare_field("best_start", exp_w.start_idx, got.start_idx);
      compare_field("best_end", exp_w.end_idx, got.end_idx);
      compare_field("best_length", exp_w.run_len, got.run_len);
      compare_field("overflow", exp_w.ovf, got.ovf);
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_wen;
  logic [7:0] cfg_wdata;

  // steady = no idling on either side, for back-to-back stretches
  bit steady;
  int unsigned stall_left;

  lowf_bit_if bits_if ();
  lowf_result_if #(.PosW(17), .IdxW(16)) result_if ();

  window_scoreboard sb = new();

  longest_ones_window_with_flips #(
    .MAX_FLIPS(MAX_FLIPS),
    .MAX_LEN  (MAX_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .bits     (bits_if),
    .result   (result_if)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Hard stop: well above the slowest legal run with every gap and stall at its longest.
  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Gap lengths: mostly short, a few long.
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned sink_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Result side: ready changes at the falling edge, random stall bursts.
  initial begin
    result_if.ready = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_if.ready = 0;
        stall_left--;
      end else begin
        result_if.ready = 1;
        if (!steady && $urandom_range(0, 99) < 20) stall_left = sink_stall();
      end
    end
  end

  // Result monitor: a transaction is taken at a rising edge with valid and ready high.
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      sb.check_window('{start_idx: result_if.best_start, end_idx: result_if.best_end,
                        run_len: result_if.best_length, ovf: result_if.overflow});
    end
  end

  // Drive one bit transaction; called and returns at a falling edge.
  // valid stays high across back-to-back transactions.
  task automatic send_bit(bit b, bit is_last);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      bits_if.valid = 0;
      repeat (gap) @(negedge clk);
    end
    bits_if.valid = 1;
    bits_if.in_bit = b;
    bits_if.in_last = is_last;
    @(posedge clk);
    while (!bits_if.ready) @(posedge clk);
    sb.note_bit(b, is_last);
    @(negedge clk);
  endtask

  // Directed streams written as strings of '0'/'1'; end mark on the final char.
  task automatic send_pattern(string s);
    for (int i = 0; i < s.len(); i++) send_bit(s[i] == "1", i == s.len() - 1);
  endtask

  // Random stream; ones_pct sets the density of ones.
  task automatic send_stream(int unsigned len, int unsigned ones_pct);
    for (int unsigned i = 0; i < len; i++)
      send_bit($urandom_range(0, 99) < ones_pct, i == len - 1);
  endtask

  // Wait until every expected window is back, then let the pipe settle:
  // a non-last transaction leaves no result but can still be in flight.
  task automatic drain();
    bits_if.valid = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_budget(logic [7:0] value);
    drain();
    cfg_wen = 1;
    cfg_wdata = value;
    sb.set_budget(value);
    @(negedge clk);
    cfg_wen = 0;
  endtask

  // Mostly short streams, some medium, a rare long one; now and then the
  // sender holds off until all results are in. The last stream is cut to fit.
  task automatic random_phase(int unsigned n_bits);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    int unsigned dens[5];
    dens = '{5, 30, 50, 70, 95};
    sent = 0;
    while (sent < n_bits) begin
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 24);
      else if (r < 96) len = $urandom_range(25, 80);
      else len = $urandom_range(200, 400);
      if (len > n_bits - sent) len = n_bits - sent;
      if ($urandom_range(0, 99) < 3) drain();
      send_stream(len, dens[$urandom_range(0, 4)]);
      sent += len;
    end
  endtask

  initial begin
    int unsigned budgets[8];
    rst = 1;
    cfg_wen = 0;
    cfg_wdata = '0;
    bits_if.valid = 0;
    bits_if.in_bit = 0;
    bits_if.in_last = 0;
    steady = 0;
    repeat (2) @(negedge clk);
    rst = 0;

    // Directed, reset budget of 0: lone zero (first item recorded with
    // length 0), all zeros (empty answer), lone one, a tie, a later win.
    send_pattern("0");
    send_pattern("000");
    send_pattern("1");
    send_pattern("101");
    send_pattern("011");
    // One flip allowed: window jumps past the oldest zero.
    write_budget(8'd1);
    send_pattern("101101");
    send_pattern("0010");
    // Top budget: every zero fits.
    write_budget(8'd255);
    send_pattern("00001");

    budgets = '{0, 1, 2, 3, 8, 255, $urandom_range(0, 255), 40};
    foreach (budgets[p]) begin
      write_budget(budgets[p][7:0]);
      steady = (p == 2 || p == 5);
      random_phase(150);
      // at the top budget, push the zero FIFO to full and past it
      if (p == 5) begin
        send_stream(300, 0);
      end
    end

    // back-to-back end marks: fresh state for each stream
    steady = 1;
    send_pattern("1");
    send_pattern("0");
    steady = 0;

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
